>>> rtl/fprc8_pkg.sv
`default_nettype none
// Shared types, codes and the CRC-8 byte fold for the framed packet receiver.
// No dependencies; used by fprc8_step and framed_packet_receiver_crc8_core.
package fprc8_pkg;

    localparam logic [7:0] SYM_STX     = 8'h02;
    localparam logic [7:0] SYM_ETX     = 8'h03;
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [3:0] NIBBLE_MASK = 4'h F;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_IDLE     = 3'd0,
        STAT_BUSY     = 3'd1,
        STAT_DONE     = 3'd2,
        STAT_BADSYM   = 3'd3,
        STAT_BADCRC   = 3'd4,
        STAT_OVERFLOW = 3'd5,
        STAT_TIMEOUT  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_CRC_BEFORE_ETX = 2'd0,
        CFG_MAX_LENGTH     = 2'd1,
        CFG_TIMEOUT_TICKS  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        crc_before_etx;
        logic [7:0]  max_length;
        logic [31:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic        have_start;
        logic        have_end;
        logic        expect_high;
        logic [3:0]  high_nibble;
        logic [7:0]  position;
        logic [7:0]  running_crc;
        logic [31:0] elapsed;
    } frame_state_t;

    typedef struct packed {
        status_t    status;
        logic       data_valid;
        logic [7:0] data_index;
        logic [7:0] data_value;
        logic [7:0] frame_length;
    } result_t;

    // Frame fields as after reset or a start (activity left to the caller).
    localparam frame_state_t FRAME_CLEAR = '{
        active:      1'b0,
        have_start:  1'b0,
        have_end:    1'b0,
        expect_high: 1'b1,
        high_nibble: 4'h0,
        position:    8'h00,
        running_crc: 8'h00,
        elapsed:     32'h0
    };

    // Reflected CRC-8, one byte, LSB first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fprc8_step.sv
`default_nettype none
// Next-state and result logic for one item of the framed packet receiver.
// Purely combinational; depends on fprc8_pkg.
module fprc8_step (
    input  wire fprc8_pkg::frame_state_t state_i,
    input  wire fprc8_pkg::cfg_t         cfg_i,
    input  wire fprc8_pkg::op_t          op_i,
    input  wire logic [7:0]              sym_i,
    output      fprc8_pkg::frame_state_t state_o,
    output      fprc8_pkg::result_t      result_o
);

    logic [3:0]  sym_hi;
    logic [3:0]  sym_lo;
    logic        sym_ok;
    logic [7:0]  byte_val;
    logic [31:0] elapsed_inc;
    logic        timeout_zero;

    assign sym_hi       = sym_i[7:4];
    assign sym_lo       = sym_i[3:0];
    assign sym_ok       = (sym_hi == (sym_lo ^ fprc8_pkg::NIBBLE_MASK));
    assign byte_val     = {state_i.high_nibble, sym_hi};
    assign elapsed_inc  = (&state_i.elapsed) ? state_i.elapsed : state_i.elapsed + 32'd1;
    assign timeout_zero = (cfg_i.timeout_ticks == 32'd0);

    always_comb begin
        state_o               = state_i;
        result_o.status       = state_i.active ? fprc8_pkg::STAT_BUSY : fprc8_pkg::STAT_IDLE;
        result_o.data_valid   = 1'b0;
        result_o.data_index   = 8'h00;
        result_o.data_value   = 8'h00;
        result_o.frame_length = 8'h00;

        case (op_i)
            fprc8_pkg::OP_START: begin
                state_o         = fprc8_pkg::FRAME_CLEAR;
                state_o.active  = !timeout_zero;
                result_o.status = timeout_zero ? fprc8_pkg::STAT_TIMEOUT
                                               : fprc8_pkg::STAT_BUSY;
            end
            fprc8_pkg::OP_TICK: begin
                if (state_i.active) begin
                    state_o.elapsed = elapsed_inc;
                    if (elapsed_inc >= cfg_i.timeout_ticks) begin
                        state_o.active  = 1'b0;
                        result_o.status = fprc8_pkg::STAT_TIMEOUT;
                    end
                end
            end
            fprc8_pkg::OP_SYMBOL: begin
                if (state_i.active) begin
                    if (sym_i == fprc8_pkg::SYM_STX) begin
                        // STX restarts the frame and the timer
                        state_o            = fprc8_pkg::FRAME_CLEAR;
                        state_o.have_start = 1'b1;
                        state_o.active     = !timeout_zero;
                        if (timeout_zero) begin
                            result_o.status = fprc8_pkg::STAT_TIMEOUT;
                        end
                    end else if (sym_i == fprc8_pkg::SYM_ETX) begin
                        if (state_i.have_start) begin
                            if (cfg_i.crc_before_etx) begin
                                // last stored byte was the CRC: residue must be zero
                                state_o.active = 1'b0;
                                if (state_i.position == 8'h00 ||
                                    state_i.running_crc != 8'h00) begin
                                    result_o.status = fprc8_pkg::STAT_BADCRC;
                                end else begin
                                    result_o.status       = fprc8_pkg::STAT_DONE;
                                    result_o.frame_length = state_i.position - 8'd1;
                                end
                            end else begin
                                state_o.have_end = 1'b1;
                            end
                        end
                    end else if (state_i.have_start) begin
                        if (!sym_ok) begin
                            state_o.active  = 1'b0;
                            result_o.status = fprc8_pkg::STAT_BADSYM;
                        end else if (state_i.expect_high) begin
                            state_o.high_nibble = sym_hi;
                            state_o.expect_high = 1'b0;
                        end else begin
                            state_o.expect_high = 1'b1;
                            if (state_i.have_end) begin
                                // trailing CRC byte closes the frame
                                state_o.active = 1'b0;
                                if (state_i.running_crc != byte_val) begin
                                    result_o.status = fprc8_pkg::STAT_BADCRC;
                                end else begin
                                    result_o.status       = fprc8_pkg::STAT_DONE;
                                    result_o.frame_length = state_i.position;
                                end
                            end else if (state_i.position < cfg_i.max_length) begin
                                result_o.data_valid = 1'b1;
                                result_o.data_index = state_i.position;
                                result_o.data_value = byte_val;
                                state_o.running_crc =
                                    fprc8_pkg::crc8_fold(state_i.running_crc, byte_val);
                                state_o.position    = state_i.position + 8'd1;
                            end else begin
                                state_o.active  = 1'b0;
                                result_o.status = fprc8_pkg::STAT_OVERFLOW;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/framed_packet_receiver_crc8_core.sv
`default_nettype none
// Top level of the framed packet receiver: config registers, frame state,
// two-entry result buffer. Depends on fprc8_pkg and fprc8_step.
//
// Usage:
//   s_ channel: one item per handshake, s_op (start, symbol, tick, no-op) and
//   s_rx_byte (line symbol). m_ channel: one result item per input item with
//   status, decoded byte (data_valid/index/value) and frame_length.
//   cfg_ channel: cfg_index selects crc_before_etx (0), max_length (1) or
//   timeout_ticks (2); cfg_wdata carries the value, low bits taken. Other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// Throughput: one item per cycle unless stalled; each result is registered.
//   The frame state update (nibble check, one CRC-8 byte fold, 32-bit tick
//   compare) completes in the accepting cycle.
// Stall: results go into a two-entry buffer (output register plus skid
//   register). s_ready drops only while both entries are full, i.e. after
//   m_ready has been low with a result waiting and another item came in.
// Reset (aresetn low, synchronous): block idle, frame state cleared, buffer
//   empty, registers back to crc_before_etx 1, max_length 255,
//   timeout_ticks 1000.
module framed_packet_receiver_crc8_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [7:0]  s_rx_byte,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [2:0]  m_status,
    output      logic        m_data_valid,
    output      logic [7:0]  m_data_index,
    output      logic [7:0]  m_data_value,
    output      logic [7:0]  m_frame_length,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    fprc8_pkg::cfg_t         cfg_reg;
    fprc8_pkg::cfg_t         cfg_next;
    fprc8_pkg::frame_state_t state_reg;
    fprc8_pkg::frame_state_t state_next;
    fprc8_pkg::frame_state_t step_state;
    fprc8_pkg::result_t      step_result;
    fprc8_pkg::result_t      out_reg;
    fprc8_pkg::result_t      skid_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;

    logic s_accept;
    logic out_load_new;
    logic out_from_skid;
    logic skid_load;

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (fprc8_pkg::cfg_index_t'(cfg_index))
                fprc8_pkg::CFG_CRC_BEFORE_ETX: cfg_next.crc_before_etx = cfg_wdata[0];
                fprc8_pkg::CFG_MAX_LENGTH:     cfg_next.max_length     = cfg_wdata[7:0];
                fprc8_pkg::CFG_TIMEOUT_TICKS:  cfg_next.timeout_ticks  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_before_etx <= 1'b1;
            cfg_reg.max_length     <= 8'd255;
            cfg_reg.timeout_ticks  <= 32'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- frame state ----------------
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    fprc8_step u_step (
        .state_i  (state_reg),
        .cfg_i    (cfg_reg),
        .op_i     (fprc8_pkg::op_t'(s_op)),
        .sym_i    (s_rx_byte),
        .state_o  (step_state),
        .result_o (step_result)
    );

    assign state_next = s_accept ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fprc8_pkg::FRAME_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- result buffer ----------------
    // New result goes to the output register when it is free or draining,
    // otherwise to the skid register; the skid entry refills the output.
    assign out_from_skid = skid_valid_reg && m_ready;
    assign out_load_new  = s_accept && (!out_valid_reg || m_ready);
    assign skid_load     = s_accept && out_valid_reg && !m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_from_skid || out_load_new) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        skid_valid_next = skid_valid_reg;
        if (skid_load) begin
            skid_valid_next = 1'b1;
        end else if (out_from_skid) begin
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_from_skid) begin
            out_reg <= skid_reg;
        end else if (out_load_new) begin
            out_reg <= step_result;
        end
        if (skid_load) begin
            skid_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_data_valid   = out_reg.data_valid;
    assign m_data_index   = out_reg.data_index;
    assign m_data_value   = out_reg.data_value;
    assign m_frame_length = out_reg.frame_length;

endmodule

`default_nettype wire

>>> test/framed_packet_receiver_crc8_checker.sv
`timescale 1ns / 100ps
// Scoreboard for framed_packet_receiver_crc8_core: watches the item, result
// and register channels, predicts every result and compares it field by field.
// Depends on fprc8_pkg for codes and result types.
module framed_packet_receiver_crc8_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic        m_data_valid,
    input  logic [7:0]  m_data_index,
    input  logic [7:0]  m_data_value,
    input  logic [7:0]  m_frame_length,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatch_count,
    output int          pending_count
);
    import fprc8_pkg::*;

    cfg_t        cfg;
    logic        rx_active;
    logic        got_stx;
    logic        got_etx;
    logic        want_high;
    logic [3:0]  held_nibble;
    logic [7:0]  stored;
    logic [7:0]  crc_acc;
    logic [31:0] ticks;
    result_t     due_results[$];

    initial pending_count = 0;

    // Reflected CRC-8, byte folded in first, then eight shifts.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void restart_frame();
        got_stx     = 1'b0;
        got_etx     = 1'b0;
        want_high   = 1'b1;
        held_nibble = 4'h0;
        stored      = 8'h00;
        crc_acc     = 8'h00;
        ticks       = 32'h0;
    endfunction

    // One input item through the receiver; returns the result it causes.
    function automatic result_t receive_item(input op_t op, input logic [7:0] sym);
        result_t    r;
        logic [3:0] hi;
        logic [7:0] b;
        r = '0;
        if (rx_active) r.status = STAT_BUSY;
        else r.status = STAT_IDLE;
        hi = sym[7:4];
        b  = {held_nibble, hi};
        case (op)
            OP_START: begin
                rx_active = 1'b1;
                restart_frame();
                r.status = STAT_BUSY;
                if (cfg.timeout_ticks == 32'h0) begin
                    rx_active = 1'b0;
                    r.status  = STAT_TIMEOUT;
                end
            end
            OP_TICK: begin
                if (rx_active) begin
                    if (ticks != 32'hFFFF_FFFF) ticks = ticks + 32'h1;
                    if (ticks >= cfg.timeout_ticks) begin
                        rx_active = 1'b0;
                        r.status  = STAT_TIMEOUT;
                    end
                end
            end
            OP_SYMBOL: begin
                if (!rx_active) begin
                    // idle: symbol dropped
                end else if (sym == SYM_STX) begin
                    restart_frame();
                    got_stx = 1'b1;
                    if (cfg.timeout_ticks == 32'h0) begin
                        rx_active = 1'b0;
                        r.status  = STAT_TIMEOUT;
                    end
                end else if (sym == SYM_ETX) begin
                    if (got_stx && cfg.crc_before_etx) begin
                        rx_active = 1'b0;
                        if (stored == 8'h00 || crc_acc != 8'h00) begin
                            r.status = STAT_BADCRC;
                        end else begin
                            r.status       = STAT_DONE;
                            r.frame_length = stored - 8'd1;
                        end
                    end else if (got_stx) begin
                        got_etx = 1'b1;
                    end
                end else if (got_stx) begin
                    if (hi != ~sym[3:0]) begin
                        rx_active = 1'b0;
                        r.status  = STAT_BADSYM;
                    end else if (want_high) begin
                        held_nibble = hi;
                        want_high   = 1'b0;
                    end else begin
                        want_high = 1'b1;
                        if (got_etx) begin
                            // trailing CRC byte closes the frame
                            rx_active = 1'b0;
                            if (crc_acc != b) begin
                                r.status = STAT_BADCRC;
                            end else begin
                                r.status       = STAT_DONE;
                                r.frame_length = stored;
                            end
                        end else if (stored < cfg.max_length) begin
                            r.data_valid = 1'b1;
                            r.data_index = stored;
                            r.data_value = b;
                            crc_acc      = crc_step(crc_acc, b);
                            stored       = stored + 8'd1;
                        end else begin
                            rx_active = 1'b0;
                            r.status  = STAT_OVERFLOW;
                        end
                    end
                end
            end
            default: begin
                // no-op leaves everything alone
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg.crc_before_etx = 1'b1;
            cfg.max_length     = 8'd255;
            cfg.timeout_ticks  = 32'd1000;
            rx_active          = 1'b0;
            restart_frame();
            due_results.delete();
            mismatch_count     = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CRC_BEFORE_ETX: cfg.crc_before_etx = cfg_wdata[0];
                    CFG_MAX_LENGTH:     cfg.max_length     = cfg_wdata[7:0];
                    CFG_TIMEOUT_TICKS:  cfg.timeout_ticks  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no item pending, status %0d", $time,
                                 m_status);
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.status || m_data_valid !== want.data_valid ||
                        m_data_index !== want.data_index ||
                        m_data_value !== want.data_value ||
                        m_frame_length !== want.frame_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: result differs (exp/got): status %0d/%0d",
                                      " dvalid %0d/%0d index %0d/%0d value %0d/%0d",
                                      " length %0d/%0d"}, $time,
                                     want.status, m_status, want.data_valid, m_data_valid,
                                     want.data_index, m_data_index,
                                     want.data_value, m_data_value,
                                     want.frame_length, m_frame_length);
                    end
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(receive_item(op_t'(s_op), s_rx_byte));
        end
        pending_count <= due_results.size();
    end

endmodule

>>> test/tb_framed_packet_receiver_crc8_core.sv
`timescale 1ns / 100ps
// Testbench top for framed_packet_receiver_crc8_core: clock, reset, stimulus,
// register writes and the verdict. Depends on fprc8_pkg and the checker module.
module tb_framed_packet_receiver_crc8_core;
    import fprc8_pkg::*;

    // Generous bound for the watchdog; a clean run stays well below it.
    localparam int CYCLE_LIMIT = 200000;

    // How a generated frame goes wrong, if at all.
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CRC,
        FLAW_BAD_SYMBOL,
        FLAW_CUT_SHORT,
        FLAW_STALL_OUT
    } frame_flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op      = OP_NOP;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_status;
    logic        m_data_valid;
    logic [7:0]  m_data_index;
    logic [7:0]  m_data_value;
    logic [7:0]  m_frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_CRC_BEFORE_ETX;
    logic [31:0] cfg_wdata = 32'h0;

    int mismatch_count;
    int pending_count;
    int cycle_count   = 0;
    int items_sent    = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 88;

    // Stimulus-side copy of the registers, used to shape frames.
    logic        cfg_crc_first = 1'b1;
    int          cfg_max_len   = 255;
    logic [31:0] cfg_timeout   = 32'd1000;

    framed_packet_receiver_crc8_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_data_valid   (m_data_valid),
        .m_data_index   (m_data_index),
        .m_data_value   (m_data_value),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    framed_packet_receiver_crc8_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_data_valid   (m_data_valid),
        .m_data_index   (m_data_index),
        .m_data_value   (m_data_value),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result side: random backpressure at the current rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One item on s_: optional idle gap first, then hold valid until taken.
    // Valid is left high on return; the next caller lowers or reuses it.
    task automatic send_item(input op_t op, input logic [7:0] sym);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= sym;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // A byte on the line is two symbols, high nibble first, each nibble
    // followed by its complement. Ticks and no-ops may slip in between.
    task automatic send_byte(input logic [7:0] b);
        for (int h = 0; h < 2; h++) begin
            if ($urandom_range(15, 0) == 0)
                send_item($urandom_range(1, 0) ? OP_TICK : OP_NOP, 8'($urandom));
            send_item(OP_SYMBOL, (h == 0) ? {b[7:4], ~b[7:4]} : {b[3:0], ~b[3:0]});
        end
    endtask

    // Lower valid and wait until every result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Register write, only once every result has come back.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CRC_BEFORE_ETX: cfg_crc_first = value[0];
            CFG_MAX_LENGTH:     cfg_max_len   = value[7:0];
            CFG_TIMEOUT_TICKS:  cfg_timeout   = value;
            default: ;
        endcase
    endtask

    // Whole reception: start, maybe line noise, STX, payload, then CRC and
    // ETX in the order the mode asks for, or one of the flaws.
    task automatic send_frame(input int len, input frame_flaw_t flaw);
        logic [7:0] crc;
        logic [7:0] b;
        logic [3:0] n;
        int         k;
        crc = 8'h00;
        // a timeout is only worth provoking when the limit is short
        if (flaw == FLAW_STALL_OUT && cfg_timeout > 32'd30) flaw = FLAW_CUT_SHORT;
        if (flaw == FLAW_BAD_SYMBOL) len = $urandom_range(len, 0);
        send_item(OP_START, 8'($urandom));
        // anything before STX is dropped, ETX included
        case ($urandom_range(3, 0))
            0: send_item(OP_SYMBOL, 8'($urandom));
            1: send_item(OP_SYMBOL, SYM_ETX);
            default: ;
        endcase
        send_item(OP_SYMBOL, SYM_STX);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            send_byte(b);
            crc = fprc8_pkg::crc8_fold(crc, b);
        end
        case (flaw)
            FLAW_BAD_SYMBOL: begin
                // broken pair, sometimes after a good high half
                n = 4'($urandom);
                if ($urandom_range(1, 0)) send_item(OP_SYMBOL, {n, ~n});
                k = $urandom_range(3, 0);
                n = 4'($urandom);
                send_item(OP_SYMBOL, {n, ~n ^ (4'h1 << k)});
            end
            FLAW_STALL_OUT: begin
                repeat (cfg_timeout + 1) send_item(OP_TICK, 8'($urandom));
            end
            FLAW_CUT_SHORT: begin
                // left open; the next start throws it away
            end
            default: begin
                if (flaw == FLAW_BAD_CRC) crc ^= 8'h01 << $urandom_range(7, 0);
                if (cfg_crc_first) begin
                    send_byte(crc);
                    send_item(OP_SYMBOL, SYM_ETX);
                end else begin
                    send_item(OP_SYMBOL, SYM_ETX);
                    send_byte(crc);
                end
            end
        endcase
    endtask

    // Mostly good frames with random payloads; some flawed frames and some
    // raw noise. Now and then a long frame: max_length + 1 bytes, capped at 12.
    task automatic run_random(input int stop_at);
        int len;
        int pick;
        while (items_sent < stop_at) begin
            pick = $urandom_range(9, 0);
            len  = $urandom_range(6, 0);
            if ($urandom_range(7, 0) == 0) len = (cfg_max_len < 12) ? cfg_max_len + 1 : 12;
            if (pick == 0) begin
                repeat ($urandom_range(4, 1))
                    send_item(op_t'($urandom_range(3, 0)), 8'($urandom));
            end else if (pick == 1) begin
                send_frame(len, frame_flaw_t'($urandom_range(4, 1)));
            end else begin
                send_frame(len, FLAW_NONE);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, reset register values ---
        // idle block drops symbols and ticks
        send_item(OP_SYMBOL, 8'hFF);
        send_item(OP_TICK, 8'h00);
        // ETX and noise before STX are dropped; ETX on an empty frame is bad CRC
        send_item(OP_START, 8'h00);
        send_item(OP_SYMBOL, SYM_ETX);
        send_item(OP_SYMBOL, 8'hFF);
        send_item(OP_SYMBOL, SYM_STX);
        send_item(OP_SYMBOL, SYM_ETX);
        // restart while active, one byte plus CRC, a no-op, and a stray high
        // nibble that ETX discards
        send_item(OP_START, 8'hFF);
        send_item(OP_START, 8'h00);
        send_item(OP_SYMBOL, SYM_STX);
        send_byte(8'hFF);
        send_byte(fprc8_pkg::crc8_fold(8'h00, 8'hFF));
        send_item(OP_NOP, 8'hAA);
        send_item(OP_SYMBOL, 8'h3C);
        send_item(OP_SYMBOL, SYM_ETX);
        // symbol that is not nibble plus complement
        send_item(OP_START, 8'h55);
        send_item(OP_SYMBOL, SYM_STX);
        send_item(OP_SYMBOL, 8'h00);

        // CRC after ETX, max_length 1, zero timeout: start times out
        write_reg(CFG_CRC_BEFORE_ETX, 32'h0);
        write_reg(CFG_MAX_LENGTH, 32'd1);
        write_reg(CFG_TIMEOUT_TICKS, 32'h0);
        send_item(OP_START, 8'h00);
        // empty frame with trailing CRC 0x00 is good, length 0
        write_reg(CFG_TIMEOUT_TICKS, 32'd3);
        send_item(OP_START, 8'h00);
        send_item(OP_SYMBOL, SYM_STX);
        send_item(OP_SYMBOL, SYM_ETX);
        send_byte(8'h00);

        // --- random, phase 1: sender idles a little, receiver a lot ---
        write_reg(CFG_CRC_BEFORE_ETX, 32'h1);
        write_reg(CFG_MAX_LENGTH, $urandom_range(10, 5));
        write_reg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        run_random(200);

        // --- phase 2: the other way round ---
        send_idle_pct = 88;
        recv_idle_pct = 28;
        write_reg(CFG_CRC_BEFORE_ETX, 32'h0);
        write_reg(CFG_MAX_LENGTH, 32'd255);
        write_reg(CFG_TIMEOUT_TICKS, $urandom_range(30, 8));
        run_random(370);

        // --- phase 3: full rate both sides ---
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_CRC_BEFORE_ETX, 32'h1);
        write_reg(CFG_MAX_LENGTH, $urandom_range(6, 3));
        write_reg(CFG_TIMEOUT_TICKS, $urandom_range(40, 15));
        run_random(550);

        // drain, then watch for anything stray from the block
        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> framed_packet_receiver_crc8_core.f
rtl/fprc8_pkg.sv
rtl/fprc8_step.sv
rtl/framed_packet_receiver_crc8_core.sv
test/framed_packet_receiver_crc8_checker.sv
test/tb_framed_packet_receiver_crc8_core.sv
